@@ src/line_sensor_centroid_with_calibration_defines.svh @@
// Assertion macros shared by the line sensor centroid RTL.
`ifndef LINE_SENSOR_CENTROID_WITH_CALIBRATION_DEFINES_SVH
`define LINE_SENSOR_CENTROID_WITH_CALIBRATION_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define LSC_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define LSC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

@@ src/lsc_pkg.sv @@
// Package with shared constants, types and codes of the line sensor centroid.
`timescale 1ns / 1ps
package lsc_pkg;
    localparam int SENSORS     = 8;
    localparam int SAMPLE_BITS = 12;
    localparam int IDX_BITS    = 3;
    localparam int DIV_BITS    = 32;
    localparam int DCNT_BITS   = 6;

    typedef enum logic [2:0] {
        OP_FOLLOW    = 3'd0,
        OP_CAL_BEGIN = 3'd1,
        OP_CAL_TRACK = 3'd2,
        OP_CAL_CANCEL= 3'd3,
        OP_CAL_SAVE  = 3'd4,
        OP_DEFAULTS  = 3'd5,
        OP_SET_ENTRY = 3'd6,
        OP_NONE      = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        CFG_CRUISE    = 3'd0,
        CFG_THRESHOLD = 3'd1,
        CFG_DEF_WHITE = 3'd2,
        CFG_DEF_BLACK = 3'd3,
        CFG_REVERSE   = 3'd4,
        CFG_MIN_SPAN  = 3'd5
    } cfg_idx_t;

    // Divider request and reply between the top level and the divider.
    typedef struct packed {
        logic                start;
        logic [DIV_BITS-1:0] num;
        logic [DIV_BITS-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                done;
        logic [DIV_BITS-1:0] quot;
    } div_rsp_t;
endpackage

@@ src/lsc_divider.sv @@
// Bit-serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`include "line_sensor_centroid_with_calibration_defines.svh"
module lsc_divider (
    input  logic               aclk,
    input  logic               aresetn,
    input  lsc_pkg::div_req_t  req,
    output lsc_pkg::div_rsp_t  rsp
);
    logic [lsc_pkg::DIV_BITS-1:0]  quot_reg, quot_next;
    logic [lsc_pkg::DIV_BITS-1:0]  den_reg, den_next;
    logic [lsc_pkg::DIV_BITS:0]    rem_reg, rem_next;
    logic [lsc_pkg::DCNT_BITS-1:0] cnt_reg, cnt_next;
    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [lsc_pkg::DIV_BITS:0]    trial;

    // One shift-and-subtract step per cycle.
    always_comb begin
        quot_next = quot_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[lsc_pkg::DIV_BITS-1:0], quot_reg[lsc_pkg::DIV_BITS-1]};
        if (req.start) begin
            quot_next = req.num;
            den_next  = req.den;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, den_reg}) begin
                rem_next  = trial - {1'b0, den_reg};
                quot_next = {quot_reg[lsc_pkg::DIV_BITS-2:0], 1'b1};
            end else begin
                rem_next  = trial;
                quot_next = {quot_reg[lsc_pkg::DIV_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == lsc_pkg::DCNT_BITS'(lsc_pkg::DIV_BITS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quot_reg <= quot_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

    `LSC_ASSERT_NEXT(a_done_after_busy, aclk, aresetn, rsp.done, !busy_reg, "done while busy")
    `LSC_ASSERT_IMPL(a_done_one_hot, aclk, aresetn, busy_reg, !done_reg, "busy and done together")
    `LSC_ASSERT_IMPL(a_cnt_range, aclk, aresetn, busy_reg,
        cnt_reg < lsc_pkg::DCNT_BITS'(lsc_pkg::DIV_BITS), "count beyond width")
endmodule

@@ src/line_sensor_centroid_with_calibration.sv @@
// Top level of the reflectance line sensor centroid with sweep calibration.
`timescale 1ns / 1ps
`include "line_sensor_centroid_with_calibration_defines.svh"
// A follow beat normalises the eight samples one sensor at a time through a
// shared bit-serial divider, then runs one more division for the centroid.
// A sensor that needs a division is started in ST_NORM, waits in ST_NWAIT
// while the divider forms its quotient bits and is collected when the
// divider reports done. A sensor that is skipped or clamps is summed in
// ST_NORM without a division. ST_CENT decides whether the line is lost and,
// when it is seen, starts the centroid division that ST_CWAIT waits for.
// ST_OUT then loads the result. Every other operation updates the state on
// its accepting edge and goes straight to ST_OUT, which loads its result
// once the output register is free. One beat is in work at a time.
// While a result waits in the output register the next beat is taken and
// worked on; its result is held back until the output register is free.
// No clearing pass is needed after reset.
module line_sensor_centroid_with_calibration (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // operation[2:0], sample_0..7 [98:3], entry_index[101:99],
    // entry_white[113:102], entry_black[125:114], zero fill to 128
    input  logic [127:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // position[15:0], line_lost[16], lost_began[17], speed_mmps[30:18],
    // calibrating[31], short_span_mask[39:32], status[40], zero fill to 48
    output logic [47:0]  m_tdata,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [14:0]  cfg_wdata
);
    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_NORM = 6'b000010,
        ST_NWAIT= 6'b000100,
        ST_CENT = 6'b001000,
        ST_CWAIT= 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;

    localparam int SB = lsc_pkg::SAMPLE_BITS;
    localparam int IB = lsc_pkg::IDX_BITS;
    localparam int DB = lsc_pkg::DIV_BITS;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [12:0]   cruise_reg;
    logic [14:0]   thresh_reg;
    logic [SB-1:0] defw_reg, defb_reg, span_reg;
    logic          rev_reg;

    // Calibration state; white/black reset to the default values 200 and 2500.
    logic [SB-1:0] white_reg [lsc_pkg::SENSORS];
    logic [SB-1:0] black_reg [lsc_pkg::SENSORS];
    logic [SB-1:0] smin_reg  [lsc_pkg::SENSORS];
    logic [SB-1:0] smax_reg  [lsc_pkg::SENSORS];
    logic          active_reg, lost_reg;
    logic [15:0]   lastpos_reg;

    // Beat being worked on.
    logic [SB-1:0] samp_reg [lsc_pkg::SENSORS];
    logic [IB-1:0] idx_reg;
    logic [16:0]   tot_reg;
    logic [19:0]   wsum_reg;
    logic          neg_reg;
    logic          fol_reg;
    logic [47:0]   opres_reg;

    // Result register.
    logic          mvalid_reg;
    logic [47:0]   mdata_reg;

    lsc_pkg::div_req_t dreq;
    lsc_pkg::div_rsp_t drsp;

    lsc_divider u_div (.aclk(aclk), .aresetn(aresetn), .req(dreq), .rsp(drsp));

    logic          accept;
    lsc_pkg::op_t  op_in;
    logic [SB-1:0] raw_in [lsc_pkg::SENSORS];
    logic [SB-1:0] cw, cb, cr;
    logic [12:0]   nweight;
    logic [IB-1:0] kk;
    logic [21:0]   num_s;
    logic [21:0]   mag_num;
    logic [19:0]   den_c;
    logic [DB-1:0] q;
    logic [15:0]   pos_sat;
    logic [15:0]   apos;
    logic [12:0]   spd;
    logic [47:0]   op_res;
    logic [47:0]   fol_res;
    logic [7:0]    mask;
    logic          stat;
    logic          lost_now;
    logic          began;
    logic          out_free;
    logic          out_load;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign op_in    = lsc_pkg::op_t'(s_tdata[2:0]);
    assign out_free = !mvalid_reg || m_tready;
    assign out_load = (state_reg == ST_OUT) && out_free;
    always_comb begin
        for (int i = 0; i < lsc_pkg::SENSORS; i++) begin
            raw_in[i] = s_tdata[3 + i*SB +: SB];
        end
    end

    // Current sensor of the normalisation sweep.
    assign cw = white_reg[idx_reg];
    assign cb = black_reg[idx_reg];
    assign cr = samp_reg[idx_reg];
    assign kk = rev_reg ? (IB'(lsc_pkg::SENSORS - 1) - idx_reg) : idx_reg;

    // Centroid numerator 2W - 7T and its magnitude.
    assign num_s   = {1'b0, wsum_reg, 1'b0} - 22'(tot_reg) * 22'(lsc_pkg::SENSORS - 1);
    assign mag_num = num_s[21] ? (22'd0 - num_s) : num_s;
    assign den_c   = 20'(tot_reg) * 20'(lsc_pkg::SENSORS - 1);
    assign q       = drsp.quot;
    assign lost_now = (tot_reg == '0) || (tot_reg < {2'b0, thresh_reg});
    assign pos_sat = neg_reg ? ((q > DB'(32768)) ? 16'h8000 : (16'd0 - q[15:0]))
                             : ((q > DB'(32767)) ? 16'h7FFF : q[15:0]);
    assign apos    = pos_sat[15] ? (16'd0 - pos_sat) : pos_sat;
    assign spd     = ({3'b0, apos} * 19'd5 > 19'(3 * 32768)) ? (cruise_reg >> 1) : cruise_reg;

    // Weight of the current sensor, or the divider request for it or for the centroid.
    always_comb begin
        dreq    = '0;
        nweight = 13'd0;
        if (state_reg == ST_NORM) begin
            if (cb <= cw || cr <= cw) begin
                nweight = 13'd0;
            end else if (cr >= cb) begin
                nweight = 13'd4096;
            end else begin
                dreq.start = 1'b1;
                dreq.num   = DB'({cr - cw, 12'b0});
                dreq.den   = DB'(cb - cw);
            end
        end else if (state_reg == ST_CENT && !lost_now) begin
            dreq.start = 1'b1;
            dreq.num   = DB'({mag_num, 15'b0});
            dreq.den   = DB'(den_c);
        end
    end

    // Save mask over all sensors.
    always_comb begin
        for (int i = 0; i < lsc_pkg::SENSORS; i++) begin
            mask[i] = (smax_reg[i] < smin_reg[i]) || (smax_reg[i] - smin_reg[i] < span_reg);
        end
    end

    // Result of a non-follow operation, taken from the state before the beat.
    always_comb begin
        stat   = 1'b0;
        op_res = '0;
        if (op_in == lsc_pkg::OP_CAL_TRACK || op_in == lsc_pkg::OP_CAL_CANCEL ||
            op_in == lsc_pkg::OP_CAL_SAVE) begin
            stat = !active_reg;
        end
        op_res[15:0]  = lastpos_reg;
        op_res[16]    = lost_reg;
        op_res[31]    = (op_in == lsc_pkg::OP_CAL_BEGIN) ? 1'b1 :
                        ((op_in == lsc_pkg::OP_CAL_CANCEL ||
                          op_in == lsc_pkg::OP_CAL_SAVE ||
                          op_in == lsc_pkg::OP_DEFAULTS) ? 1'b0 : active_reg);
        op_res[39:32] = (op_in == lsc_pkg::OP_CAL_SAVE && active_reg) ? mask : 8'd0;
        op_res[40]    = stat;
    end

    // Result of a follow beat once the centroid is known.
    always_comb begin
        fol_res = '0;
        began   = 1'b0;
        if (lost_now) begin
            began         = !lost_reg;
            fol_res[15:0] = lastpos_reg;
            fol_res[16]   = 1'b1;
        end else begin
            fol_res[15:0]  = pos_sat;
            fol_res[30:18] = spd;
        end
        fol_res[17] = began;
        fol_res[31] = active_reg;
    end

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (accept) state_next = (op_in == lsc_pkg::OP_FOLLOW) ? ST_NORM : ST_OUT;
            ST_NORM:  if (dreq.start) state_next = ST_NWAIT;
                      else if (idx_reg == IB'(lsc_pkg::SENSORS - 1)) state_next = ST_CENT;
            ST_NWAIT: if (drsp.done) state_next = (idx_reg == IB'(lsc_pkg::SENSORS - 1))
                                                  ? ST_CENT : ST_NORM;
            ST_CENT:  state_next = lost_now ? ST_OUT : ST_CWAIT;
            ST_CWAIT: if (drsp.done) state_next = ST_OUT;
            ST_OUT:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cruise_reg  <= 13'd300;
            thresh_reg  <= 15'd2048;
            defw_reg    <= SB'(200);
            defb_reg    <= SB'(2500);
            rev_reg     <= 1'b0;
            span_reg    <= SB'(200);
            active_reg  <= 1'b0;
            lost_reg    <= 1'b0;
            lastpos_reg <= '0;
            mvalid_reg  <= 1'b0;
            for (int i = 0; i < lsc_pkg::SENSORS; i++) begin
                white_reg[i] <= SB'(200);
                black_reg[i] <= SB'(2500);
                smin_reg[i]  <= '1;
                smax_reg[i]  <= '0;
            end
        end else begin
            state_reg <= state_next;
            // Configuration writes.
            if (cfg_we) begin
                case (cfg_index)
                    lsc_pkg::CFG_CRUISE:    cruise_reg <= cfg_wdata[12:0];
                    lsc_pkg::CFG_THRESHOLD: thresh_reg <= cfg_wdata;
                    lsc_pkg::CFG_DEF_WHITE: defw_reg   <= cfg_wdata[SB-1:0];
                    lsc_pkg::CFG_DEF_BLACK: defb_reg   <= cfg_wdata[SB-1:0];
                    lsc_pkg::CFG_REVERSE:   rev_reg    <= cfg_wdata[0];
                    lsc_pkg::CFG_MIN_SPAN:  span_reg   <= cfg_wdata[SB-1:0];
                    default: ;
                endcase
            end
            // Non-follow operations update the state on the accepting edge.
            if (accept) begin
                unique case (op_in)
                    lsc_pkg::OP_FOLLOW: ;
                    lsc_pkg::OP_CAL_BEGIN: begin
                        active_reg <= 1'b1;
                        for (int i = 0; i < lsc_pkg::SENSORS; i++) begin
                            smin_reg[i] <= '1;
                            smax_reg[i] <= '0;
                        end
                    end
                    lsc_pkg::OP_CAL_TRACK: begin
                        if (active_reg) begin
                            for (int i = 0; i < lsc_pkg::SENSORS; i++) begin
                                if (raw_in[i] < smin_reg[i]) smin_reg[i] <= raw_in[i];
                                if (raw_in[i] > smax_reg[i]) smax_reg[i] <= raw_in[i];
                            end
                        end
                    end
                    lsc_pkg::OP_CAL_CANCEL: begin
                        active_reg <= 1'b0;
                    end
                    lsc_pkg::OP_CAL_SAVE: begin
                        if (active_reg) begin
                            active_reg <= 1'b0;
                            for (int i = 0; i < lsc_pkg::SENSORS; i++) begin
                                if (!mask[i]) begin
                                    white_reg[i] <= smin_reg[i];
                                    black_reg[i] <= smax_reg[i];
                                end
                            end
                        end
                    end
                    lsc_pkg::OP_DEFAULTS: begin
                        active_reg <= 1'b0;
                        for (int i = 0; i < lsc_pkg::SENSORS; i++) begin
                            white_reg[i] <= defw_reg;
                            black_reg[i] <= defb_reg;
                        end
                    end
                    lsc_pkg::OP_SET_ENTRY: begin
                        white_reg[s_tdata[101:99]] <= s_tdata[113:102];
                        black_reg[s_tdata[101:99]] <= s_tdata[125:114];
                    end
                    default: ;
                endcase
            end
            // Follow state moves on as its result is loaded.
            if (out_load && fol_reg) begin
                if (lost_now) begin
                    lost_reg <= 1'b1;
                end else begin
                    lost_reg    <= 1'b0;
                    lastpos_reg <= pos_sat;
                end
            end
            // Output register: loaded when free or being emptied.
            if (out_load) begin
                mdata_reg  <= fol_reg ? fol_res : opres_reg;
                mvalid_reg <= 1'b1;
            end else if (m_tvalid && m_tready) begin
                mvalid_reg <= 1'b0;
            end
        end
    end

    // Datapath of the follow sweep and capture of the accepted beat.
    always_ff @(posedge aclk) begin
        if (accept) begin
            for (int i = 0; i < lsc_pkg::SENSORS; i++) samp_reg[i] <= raw_in[i];
            idx_reg   <= '0;
            tot_reg   <= '0;
            wsum_reg  <= '0;
            fol_reg   <= (op_in == lsc_pkg::OP_FOLLOW);
            opres_reg <= op_res;
        end
        if (state_reg == ST_NORM && !dreq.start) begin
            tot_reg  <= tot_reg + 17'(nweight);
            wsum_reg <= wsum_reg + 20'(nweight) * 20'(kk);
            if (idx_reg != IB'(lsc_pkg::SENSORS - 1)) idx_reg <= idx_reg + 1'b1;
        end
        if (state_reg == ST_NWAIT && drsp.done) begin
            tot_reg  <= tot_reg + 17'(q[12:0]);
            wsum_reg <= wsum_reg + 20'(q[12:0]) * 20'(kk);
            if (idx_reg != IB'(lsc_pkg::SENSORS - 1)) idx_reg <= idx_reg + 1'b1;
        end
        if (state_reg == ST_CENT) neg_reg <= num_s[21];
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;

    `LSC_ASSERT_IMPL(a_one_work, aclk, aresetn, state_reg != ST_IDLE, !s_tready, "ready while busy")
    `LSC_ASSERT_NEXT(a_out_valid, aclk, aresetn, state_reg == ST_OUT, m_tvalid, "no result")
    `LSC_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata), "result changed while waiting")
endmodule
